// ===== sv/line_segment_clip_rect_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the line segment clipper.
// Shared forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_CLIP_RECT_MACROS_SVH
`define LINE_SEGMENT_CLIP_RECT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define LSCR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line_segment_clip_rect: assertion failed");

// Next-cycle implication, ignored while reset is held.
`define LSCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line_segment_clip_rect: assertion failed");

// Next-cycle implication that also holds across reset.
`define LSCR_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("line_segment_clip_rect: reset assertion failed");

`endif

// ===== sv/lscr_pkg.sv =====
// ----------------------------------------------------------------------------
// lscr_pkg
// Types, constants and helper functions of the line segment clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package lscr_pkg;

  // Coordinate width and derived widths of the slope arithmetic.
  localparam int CW    = 16;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int CNT_W = $clog2(PW + 1);

  // Register interface.
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 4;
  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MIN = 2'd1;
  localparam logic [1:0] REG_X_MAX = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  // Region outcode bits.
  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  localparam logic [3:0] MAX_MOVES = 4'd8;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t WIN_MIN_RESET = coord_t'(150);
  localparam coord_t WIN_MAX_RESET = coord_t'(350);

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_t;

  typedef struct packed {
    logic   accepted;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } res_t;

  typedef struct packed {
    coord_t x_min;
    coord_t y_min;
    coord_t x_max;
    coord_t y_max;
  } win_t;

  // One classified segment as it waits between front and back.
  typedef struct packed {
    seg_t       seg;
    logic [3:0] c1;
    logic [3:0] c2;
  } job_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Outcode of one point against the window.
  function automatic logic [3:0] region(coord_t x, coord_t y, win_t w);
    logic [3:0] c;
    c = 4'd0;
    if (x < w.x_min) c = c | CODE_LEFT;
    if (x > w.x_max) c = c | CODE_RIGHT;
    if (y < w.y_min) c = c | CODE_BOTTOM;
    if (y > w.y_max) c = c | CODE_TOP;
    return c;
  endfunction

  // Magnitude of a difference; the most negative value maps to 2^CW.
  function automatic logic [DW-1:0] mag(logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

endpackage

`default_nettype wire

// ===== sv/lscr_front.sv =====
// ----------------------------------------------------------------------------
// lscr_front
// Accepts segments and tags both endpoints with their region outcodes.
// ----------------------------------------------------------------------------
`default_nettype none

module lscr_front import lscr_pkg::*; (
  input  wire logic   push,
  output logic        full,
  input  wire seg_t   in_data,
  input  wire win_t   win,
  input  wire qstat_t qstat,
  output logic        q_push,
  output job_t        q_wdata
);

  // A segment enters whenever the queue has room.
  assign full   = qstat.full;
  assign q_push = push && !qstat.full;

  // Classify both endpoints against the current window.
  always_comb begin
    q_wdata.seg = in_data;
    q_wdata.c1  = region(in_data.start_x, in_data.start_y, win);
    q_wdata.c2  = region(in_data.end_x, in_data.end_y, win);
  end

endmodule

`default_nettype wire

// ===== sv/lscr_fifo.sv =====
// ----------------------------------------------------------------------------
// lscr_fifo
// Two-entry queue of classified segments between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lscr_fifo import lscr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire job_t wdata,
  input  wire logic rd_en,
  output job_t      rdata,
  output qstat_t    qstat
);

  job_t       mem_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;

  assign rdata       = mem_r[rptr_r];
  assign qstat.full  = (cnt_r == 2'd2);
  assign qstat.empty = (cnt_r == 2'd0);

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en) wptr_r <= ~wptr_r;
      if (rd_en) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wptr_r] <= wdata;
  end

endmodule

`default_nettype wire

// ===== sv/lscr_back.sv =====
// ----------------------------------------------------------------------------
// lscr_back
// Edge-move sequencer with a shared multiplier and bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lscr_back import lscr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire win_t   win,
  input  wire qstat_t qstat,
  input  wire job_t   q_rdata,
  output logic        q_pop,
  input  wire logic   pop,
  output logic        empty,
  output res_t        out_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]       state_r;
  coord_t           x1_r, y1_r, x2_r, y2_r;
  logic [3:0]       c1_r, c2_r;
  logic [3:0]       moves_r;
  logic             ok_r;
  logic [DW-1:0]    amag_r, bmag_r, cmag_r;
  logic             neg_r;
  logic             vert_r;
  logic             sel2_r;
  coord_t           e_r;
  logic [PW-1:0]    prod_r;
  logic [DW:0]      rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  res_t             out_r;

  // Move setup terms, taken from the current endpoints.
  logic                 pick2;
  logic [3:0]           code;
  logic                 vert;
  coord_t               px, py, e;
  logic signed [DW-1:0] dx, dy, da, db, dc;

  always_comb begin
    pick2 = (c1_r == 4'd0);
    code  = pick2 ? c2_r : c1_r;
    px    = pick2 ? x2_r : x1_r;
    py    = pick2 ? y2_r : y1_r;
    vert  = |(code & (CODE_LEFT | CODE_RIGHT));
    dx    = DW'(x2_r) - DW'(x1_r);
    dy    = DW'(y2_r) - DW'(y1_r);
    if (vert) begin
      e  = |(code & CODE_LEFT) ? win.x_min : win.x_max;
      da = DW'(e) - DW'(px);
      db = dy;
      dc = dx;
    end else begin
      e  = |(code & CODE_BOTTOM) ? win.y_min : win.y_max;
      da = DW'(e) - DW'(py);
      db = dx;
      dc = dy;
    end
  end

  // One restoring division step.
  logic [DW:0] rem_sh;
  logic        qbit;

  always_comb begin
    rem_sh = {rem_r[DW-1:0], prod_r[PW-1]};
    qbit   = (rem_sh >= {1'b0, cmag_r});
  end

  // Signed offset along the edge and the moved coordinate.
  logic [DW-1:0]          qmag;
  logic signed [DW:0]     qs;
  logic signed [DW:0]     base;
  logic signed [DW:0]     sum;
  coord_t                 moved;
  logic [3:0]             new_code;

  always_comb begin
    qmag = (cmag_r == '0) ? '0 : prod_r[DW-1:0];
    qs   = neg_r ? -($signed({1'b0, qmag})) : $signed({1'b0, qmag});
    if (vert_r) base = (DW + 1)'(sel2_r ? y2_r : y1_r);
    else        base = (DW + 1)'(sel2_r ? x2_r : x1_r);
    sum   = base + qs;
    moved = sum[CW-1:0];
    if (vert_r) new_code = region(e_r, moved, win);
    else        new_code = region(moved, e_r, win);
  end

  // A finished segment moves into the result register when it is free or
  // being taken in the same cycle.
  logic load_out;

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || pop);

  assign q_pop    = (state_r == ST_IDLE) && !qstat.empty;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      moves_r     <= 4'd0;
      cnt_r       <= '0;
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (pop && out_valid_r) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!qstat.empty) begin
            x1_r    <= q_rdata.seg.start_x;
            y1_r    <= q_rdata.seg.start_y;
            x2_r    <= q_rdata.seg.end_x;
            y2_r    <= q_rdata.seg.end_y;
            c1_r    <= q_rdata.c1;
            c2_r    <= q_rdata.c2;
            moves_r <= 4'd0;
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (c1_r == 4'd0 && c2_r == 4'd0) begin
            ok_r    <= 1'b1;
            state_r <= ST_DONE;
          end else if ((c1_r & c2_r) != 4'd0 || moves_r == MAX_MOVES) begin
            ok_r    <= 1'b0;
            state_r <= ST_DONE;
          end else begin
            amag_r  <= mag(da);
            bmag_r  <= mag(db);
            cmag_r  <= mag(dc);
            neg_r   <= da[DW-1] ^ db[DW-1] ^ dc[DW-1];
            vert_r  <= vert;
            sel2_r  <= pick2;
            e_r     <= e;
            moves_r <= moves_r + 4'd1;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= amag_r * bmag_r;
          rem_r   <= '0;
          cnt_r   <= CNT_W'(PW);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r  <= qbit ? (rem_sh - {1'b0, cmag_r}) : rem_sh;
          prod_r <= {prod_r[PW-2:0], qbit};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          if (vert_r) begin
            if (sel2_r) begin
              x2_r <= e_r;  y2_r <= moved;  c2_r <= new_code;
            end else begin
              x1_r <= e_r;  y1_r <= moved;  c1_r <= new_code;
            end
          end else begin
            if (sel2_r) begin
              x2_r <= moved;  y2_r <= e_r;  c2_r <= new_code;
            end else begin
              x1_r <= moved;  y1_r <= e_r;  c1_r <= new_code;
            end
          end
          state_r <= ST_EVAL;
        end
        ST_DONE: begin
          if (load_out) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result register, loaded as the result is handed over.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.accepted     <= ok_r;
      out_r.clip_start_x <= ok_r ? x1_r : '0;
      out_r.clip_start_y <= ok_r ? y1_r : '0;
      out_r.clip_end_x   <= ok_r ? x2_r : '0;
      out_r.clip_end_y   <= ok_r ? y2_r : '0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/line_segment_clip_rect.sv =====
// ----------------------------------------------------------------------------
// line_segment_clip_rect
// Cohen-Sutherland clipping of line segments against a register window.
// ----------------------------------------------------------------------------
// A segment pushed into the block is classified at once and waits in a
// two-entry queue; the clipping engine works on one segment at a time and
// accepts or rejects it trivially from its outcodes where it can, else
// moves an endpoint onto a window edge (one setup, one multiply, 34 divide
// steps and one update per move) and tests again, with at most 8 moves.
// The bit-serial divider is shared by all moves.  A result waits in
// the output register while the next segment is worked on; a finished
// segment stalls until that register is free.  Rejected segments return
// accepted low with all coordinates zero.
`default_nettype none

module line_segment_clip_rect import lscr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire seg_t              in_data,
  input  wire logic              pop,
  output logic                   empty,
  output res_t                   out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  win_t   win_r;
  qstat_t qstat;
  logic   q_push, q_pop;
  job_t   q_wdata, q_rdata;
  logic   wr_en;

  // Window registers behind the APB port.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.x_min <= WIN_MIN_RESET;
      win_r.y_min <= WIN_MIN_RESET;
      win_r.x_max <= WIN_MAX_RESET;
      win_r.y_max <= WIN_MAX_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_X_MIN: win_r.x_min <= pwdata[CW-1:0];
        REG_Y_MIN: win_r.y_min <= pwdata[CW-1:0];
        REG_X_MAX: win_r.x_max <= pwdata[CW-1:0];
        REG_Y_MAX: win_r.y_max <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[3:2])
      REG_X_MIN: prdata = APB_DW'($unsigned(win_r.x_min));
      REG_Y_MIN: prdata = APB_DW'($unsigned(win_r.y_min));
      REG_X_MAX: prdata = APB_DW'($unsigned(win_r.x_max));
      REG_Y_MAX: prdata = APB_DW'($unsigned(win_r.y_max));
      default:   prdata = '0;
    endcase
  end

  lscr_front u_front (
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .win     (win_r),
    .qstat   (qstat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  lscr_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_push),
    .wdata (q_wdata),
    .rd_en (q_pop),
    .rdata (q_rdata),
    .qstat (qstat)
  );

  lscr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .win      (win_r),
    .qstat    (qstat),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/lscr_checker.sv =====
// ----------------------------------------------------------------------------
// lscr_checker
// Port-level checks of the line segment clipper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_segment_clip_rect_macros.svh"

module lscr_checker import lscr_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic pop,
  input wire logic empty,
  input wire res_t out_data,
  input wire logic pready
);

  // All four result coordinates are zero.
  logic coords_zero;

  assign coords_zero = (out_data.clip_start_x == '0) && (out_data.clip_start_y == '0) &&
                       (out_data.clip_end_x == '0) && (out_data.clip_end_y == '0);

  // A rejected segment carries zero coordinates.
  `LSCR_ASSERT_NOW(a_reject_zero, !empty && !out_data.accepted, coords_zero)

  // A waiting result that is not taken stays put.
  `LSCR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_data))

  // No result is left over from before reset.
  `LSCR_ASSERT_RST(a_reset_empty, !rst_n, empty)

  // The register port never waits.
  `LSCR_ASSERT_NOW(a_ready, 1'b1, pready)

endmodule

bind line_segment_clip_rect lscr_checker u_lscr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .pop      (pop),
  .empty    (empty),
  .out_data (out_data),
  .pready   (pready)
);

`default_nettype wire
